### src/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expands to a labelled
// concurrent assertion in simulation and to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

### src/lfu_pkg.sv
package lfu_pkg;

    localparam int KEY_W       = 32;
    localparam int USE_COUNT_W = 16;
    localparam int CAP_W       = 5;

    typedef logic signed [KEY_W-1:0]  key_t;
    typedef logic [USE_COUNT_W-1:0]   use_count_t;
    typedef logic [CAP_W-1:0]         cap_t;

    // Capacity after reset.
    localparam cap_t CAP_RESET = 5'd16;

endpackage

### src/lfu_ram.sv
module lfu_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/lfu_cache_tracker_top.sv
// A request walks the list before its result is given: a hit waits for its entry to move
// to its new place (a saturated count does not move); a miss waits for every entry to move
// back and the new head to be written, or only for the head write when the front entry is evicted.
// Requests are taken one at a time, bounded by the single read and single write port of
// the slot memory.
// Reset (rst_n, asynchronous) empties the cache and sets capacity to 16; slots are kept.
`include "assert_macros.svh"

module lfu_cache_tracker_top #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,

    // Configuration: capacity register.
    input  logic                cfg_wr_en,
    input  lfu_pkg::cap_t       cfg_wr_data,

    // Request channel.
    input  logic                page_valid,
    output logic                page_stall,
    input  lfu_pkg::key_t       page_key,

    // Result channel.
    output logic                result_valid,
    input  logic                result_stall,
    output logic                hit,
    output logic                evicted,
    output lfu_pkg::key_t       evicted_key,
    output lfu_pkg::use_count_t use_count
);

    import lfu_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int SLOT_W = KEY_W + COUNT_BITS;
    localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_INIT = COUNT_BITS'(1);

    // The cache is held as a list in one memory, slot 0 at the front, kept in
    // ascending count order. Each slot holds the key in its upper bits and the
    // count in its lower bits. Every request walks the list:
    //   SEARCH  reads slots from the front, one per cycle, comparing keys. The
    //           read of the next slot is issued while the current one is checked.
    //   HIT     moves the entries behind the hit one place forward until one is
    //           found whose count is not below the new count or the list ends,
    //           then writes the hit entry just in front of it.
    //   INS     on a miss with room, moves every entry one place back, working
    //           from the tail towards the front.
    //   HEAD    writes the new key with a count of one into slot 0; on a miss with
    //           a full cache this overwrites the evicted front entry.
    //   DONE    hands the result to the output register once that is free.
    // Within each walk the reads run strictly ahead of (HIT) or behind (INS) the
    // writes, so an entry is never read after it has been overwritten and no
    // forwarding is needed.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_HIT,
        ST_INS,
        ST_HEAD,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [OCC_W-1:0]      idx_reg, idx_next;
    logic [OCC_W-1:0]      occ_reg, occ_next;
    cap_t                  capacity_reg, capacity_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [KEY_W-1:0]      front_key_reg, front_key_next;
    logic                  work_hit_reg, work_hit_next;
    logic                  work_evicted_reg, work_evicted_next;
    logic [KEY_W-1:0]      work_evkey_reg, work_evkey_next;

    logic                  res_valid_reg, res_valid_next;
    logic                  res_hit_reg, res_hit_next;
    logic                  res_evicted_reg, res_evicted_next;
    logic [KEY_W-1:0]      res_evkey_reg, res_evkey_next;
    use_count_t            res_count_reg, res_count_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [SLOT_W-1:0]     ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [SLOT_W-1:0]     rd_slot;
    logic [KEY_W-1:0]      rd_key;
    logic [COUNT_BITS-1:0] rd_count;

    logic [CMP_W-1:0]      cap_eff;
    logic                  full;

    lfu_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (ENTRIES)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_slot)
    );

    assign rd_key   = rd_slot[SLOT_W-1:COUNT_BITS];
    assign rd_count = rd_slot[COUNT_BITS-1:0];

    // A capacity of zero behaves as one; the entry count caps it from above.
    assign cap_eff = (capacity_reg == '0) ? CMP_W'(1) : CMP_W'(capacity_reg);
    assign full    = (occ_reg >= OCC_W'(ENTRIES)) || (CMP_W'(occ_reg) >= cap_eff);

    assign page_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        occ_next          = occ_reg;
        capacity_next     = cfg_wr_en ? cfg_wr_data : capacity_reg;
        key_next          = key_reg;
        cnt_next          = cnt_reg;
        front_key_next    = front_key_reg;
        work_hit_next     = work_hit_reg;
        work_evicted_next = work_evicted_reg;
        work_evkey_next   = work_evkey_reg;
        res_valid_next    = res_valid_reg && result_stall;
        res_hit_next      = res_hit_reg;
        res_evicted_next  = res_evicted_reg;
        res_evkey_next    = res_evkey_reg;
        res_count_next    = res_count_reg;
        ram_we            = 1'b0;
        ram_waddr         = '0;
        ram_wdata         = '0;
        ram_raddr         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Slot 0 is read here so that its data is ready in the first
                // search cycle.
                if (page_valid)
                begin
                    key_next          = page_key;
                    idx_next          = '0;
                    work_hit_next     = 1'b0;
                    work_evicted_next = 1'b0;
                    work_evkey_next   = '0;
                    state_next        = ST_SEARCH;
                end
            end

            ST_SEARCH:
            begin
                ram_raddr = IDX_W'(idx_reg + 1'b1);
                if (idx_reg == occ_reg)
                begin
                    cnt_next = COUNT_INIT;
                    if (full)
                    begin
                        work_evicted_next = 1'b1;
                        work_evkey_next   = front_key_reg;
                        state_next        = ST_HEAD;
                    end
                    else
                    begin
                        occ_next = occ_reg + 1'b1;
                        if (occ_reg == '0)
                        begin
                            state_next = ST_HEAD;
                        end
                        else
                        begin
                            ram_raddr  = IDX_W'(occ_reg - 1'b1);
                            idx_next   = occ_reg - 1'b1;
                            state_next = ST_INS;
                        end
                    end
                end
                else
                begin
                    if (idx_reg == '0)
                    begin
                        front_key_next = rd_key;
                    end
                    if (rd_key == key_reg)
                    begin
                        work_hit_next = 1'b1;
                        if (rd_count == COUNT_MAX)
                        begin
                            // A saturated entry stays where it is.
                            cnt_next   = rd_count;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            cnt_next   = rd_count + 1'b1;
                            idx_next   = idx_reg + 1'b1;
                            state_next = ST_HIT;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            ST_HIT:
            begin
                ram_raddr = IDX_W'(idx_reg + 1'b1);
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(idx_reg - 1'b1);
                if ((idx_reg == occ_reg) || (rd_count >= cnt_reg))
                begin
                    ram_wdata  = {key_reg, cnt_reg};
                    state_next = ST_DONE;
                end
                else
                begin
                    ram_wdata = rd_slot;
                    idx_next  = idx_reg + 1'b1;
                end
            end

            ST_INS:
            begin
                ram_raddr = IDX_W'(idx_reg - 1'b1);
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(idx_reg + 1'b1);
                ram_wdata = rd_slot;
                if (idx_reg == '0)
                begin
                    state_next = ST_HEAD;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end

            ST_HEAD:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = {key_reg, cnt_reg};
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_valid_next   = 1'b1;
                    res_hit_next     = work_hit_reg;
                    res_evicted_next = work_evicted_reg;
                    res_evkey_next   = work_evkey_reg;
                    res_count_next   = USE_COUNT_W'(cnt_reg);
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            capacity_reg  <= CAP_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            capacity_reg  <= capacity_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        idx_reg          <= idx_next;
        key_reg          <= key_next;
        cnt_reg          <= cnt_next;
        front_key_reg    <= front_key_next;
        work_hit_reg     <= work_hit_next;
        work_evicted_reg <= work_evicted_next;
        work_evkey_reg   <= work_evkey_next;
        res_hit_reg      <= res_hit_next;
        res_evicted_reg  <= res_evicted_next;
        res_evkey_reg    <= res_evkey_next;
        res_count_reg    <= res_count_next;
    end

    assign result_valid = res_valid_reg;
    assign hit          = res_hit_reg;
    assign evicted      = res_evicted_reg;
    assign evicted_key  = key_t'(res_evkey_reg);
    assign use_count    = res_count_reg;

    `ASSERT_NEVER(a_occ_bound, clk, rst_n, occ_reg > OCC_W'(ENTRIES), "occupancy exceeds entry count")
    `ASSERT_PROP(a_occ_step, clk, rst_n, (occ_reg != $past(occ_reg)) |-> (occ_reg == $past(occ_reg) + 1'b1), "occupancy moved by other than one")
    `ASSERT_NEVER(a_hit_no_evict, clk, rst_n, res_valid_reg && res_hit_reg && res_evicted_reg, "hit reported with an eviction")
    `ASSERT_NEVER(a_evkey_zero, clk, rst_n, res_valid_reg && !res_evicted_reg && (res_evkey_reg != '0), "evicted key not zero without an eviction")
    `ASSERT_NEVER(a_write_state, clk, rst_n, ram_we && ((state_reg == ST_IDLE) || (state_reg == ST_SEARCH) || (state_reg == ST_DONE)), "slot memory written outside a list update")

endmodule
